### rtl/mrgs_pkg.sv
// Merge sorter package: sizes, shared types, controller/datapath command and status.
// No dependencies.
`default_nettype none

package mrgs_pkg;

    localparam int unsigned MAX_ITEMS = 64;
    localparam int unsigned DATA_W    = 32;
    localparam int unsigned ADDR_W    = $clog2(MAX_ITEMS);
    localparam int unsigned CNT_W     = $clog2(MAX_ITEMS + 1);

    typedef logic        [CNT_W-1:0]  t_cnt;
    typedef logic        [ADDR_W-1:0] t_addr;
    typedef logic signed [DATA_W-1:0] t_data;

    typedef enum logic [4:0] {
        ST_LOAD    = 5'b00001,
        ST_PRIME   = 5'b00010,
        ST_MERGE   = 5'b00100,
        ST_EMIT_RD = 5'b01000,
        ST_EMIT    = 5'b10000
    } t_state;

    typedef struct packed {
        logic load;     // input item taken
        logic start;    // input item taken carries last
        logic prime;    // issue head reads for a new pass
        logic merge;    // one merge step
        logic emit_rd;  // issue first read of sorted batch
        logic emit;     // result presented
        logic step;     // result taken
    } t_dp_cmd;

    typedef struct packed {
        logic multi;    // batch holds two or more values after this load
        logic pass_end; // this merge step writes the last entry of the pass
        logic sort_end; // ... and that pass was the final one
        logic emit_end; // presented result is the final one
    } t_dp_stat;

endpackage

`default_nettype wire

### rtl/mrgs_if.sv
// Merge sorter channel interfaces: input item and result item, valid/ready.
// Depends on mrgs_pkg.
`default_nettype none

interface mrgs_in_if;
    import mrgs_pkg::*;
    logic  valid;
    logic  ready;
    t_data value;
    logic  last;

    modport source (output valid, output value, output last, input ready);
    modport sink   (input valid, input value, input last, output ready);
endinterface

interface mrgs_out_if;
    import mrgs_pkg::*;
    logic  valid;
    logic  ready;
    t_data sorted_value;
    logic  end_of_batch;
    logic  overflow;

    modport source (output valid, output sorted_value, output end_of_batch,
                    output overflow, input ready);
    modport sink   (input valid, input sorted_value, input end_of_batch,
                    input overflow, output ready);
endinterface

`default_nettype wire

### rtl/mrgs_ram.sv
// Generic RAM: one write port, two read ports with registered read data.
// No dependencies.
`default_nettype none

module mrgs_ram #(
    parameter int unsigned WIDTH = 32,
    parameter int unsigned DEPTH = 64
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr_a,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr_b,
    output logic      [WIDTH-1:0]         o_rdata_a,
    output logic      [WIDTH-1:0]         o_rdata_b
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata_a <= r_mem[i_raddr_a];
        o_rdata_b <= r_mem[i_raddr_b];
    end

endmodule

`default_nettype wire

### rtl/mrgs_ctrl.sv
// Merge sorter controller: load / prime / merge / emit sequencing.
// Depends on mrgs_pkg.
`default_nettype none

module mrgs_ctrl import mrgs_pkg::*; (
    input  wire logic     i_clk,
    input  wire logic     i_rst_n,
    input  wire logic     i_in_valid,
    input  wire logic     i_in_last,
    input  wire logic     i_out_ready,
    input  wire t_dp_stat i_stat,
    output logic          o_in_ready,
    output logic          o_out_valid,
    output t_dp_cmd       o_cmd
);

    t_state r_state, n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_LOAD;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_LOAD: begin
                if (i_in_valid && i_in_last) begin
                    n_state = i_stat.multi ? ST_PRIME : ST_EMIT_RD;
                end
            end
            ST_PRIME: begin
                n_state = ST_MERGE;
            end
            ST_MERGE: begin
                if (i_stat.sort_end) begin
                    n_state = ST_EMIT_RD;
                end else if (i_stat.pass_end) begin
                    n_state = ST_PRIME;
                end
            end
            ST_EMIT_RD: begin
                n_state = ST_EMIT;
            end
            ST_EMIT: begin
                if (i_out_ready && i_stat.emit_end) begin
                    n_state = ST_LOAD;
                end
            end
            default: begin
                n_state = ST_LOAD;
            end
        endcase
    end

    assign o_in_ready    = (r_state == ST_LOAD);
    assign o_out_valid   = (r_state == ST_EMIT);
    assign o_cmd.load    = (r_state == ST_LOAD) && i_in_valid;
    assign o_cmd.start   = (r_state == ST_LOAD) && i_in_valid && i_in_last;
    assign o_cmd.prime   = (r_state == ST_PRIME);
    assign o_cmd.merge   = (r_state == ST_MERGE);
    assign o_cmd.emit_rd = (r_state == ST_EMIT_RD);
    assign o_cmd.emit    = (r_state == ST_EMIT);
    assign o_cmd.step    = (r_state == ST_EMIT) && i_out_ready;

endmodule

`default_nettype wire

### rtl/mrgs_datapath.sv
// Merge sorter datapath: two ping-pong banks, run pointers, fill count, result fields.
// Depends on mrgs_pkg and mrgs_ram.
`default_nettype none

module mrgs_datapath import mrgs_pkg::*; (
    input  wire logic    i_clk,
    input  wire logic    i_rst_n,
    input  wire t_dp_cmd i_cmd,
    output t_dp_stat     o_stat,
    input  wire t_data   i_value,
    output t_data        o_sorted_value,
    output logic         o_end_of_batch,
    output logic         o_overflow
);

    t_cnt  r_count, n_count;
    logic  r_dropped, n_dropped;
    logic  r_src, n_src;
    t_cnt  r_width, n_width;
    t_cnt  r_i, n_i;
    t_cnt  r_j, n_j;
    t_cnt  r_mid, n_mid;
    t_cnt  r_hi, n_hi;
    t_cnt  r_o, n_o;
    t_addr r_k, n_k;

    t_addr raddr_a, raddr_b, waddr;
    t_data wdata;
    logic  we0, we1;
    t_data b0_rd_a, b0_rd_b, b1_rd_a, b1_rd_b;

    t_data src_a, src_b, merge_data;
    logic  has_i, has_j, take_a;
    t_cnt  i_nx, j_nx, o_nx, count_nx;
    logic  full, pair_end, pass_end;
    logic [CNT_W:0] w2, sum_mid, sum_hi, cnt_x;
    t_cnt  nx_mid, nx_hi, p_mid, p_hi;
    t_addr k_inc;
    logic  emit_end;

    mrgs_ram #(.WIDTH(DATA_W), .DEPTH(MAX_ITEMS)) u_bank0 (
        .i_clk     (i_clk),
        .i_we      (we0),
        .i_waddr   (waddr),
        .i_wdata   (wdata),
        .i_raddr_a (raddr_a),
        .i_raddr_b (raddr_b),
        .o_rdata_a (b0_rd_a),
        .o_rdata_b (b0_rd_b)
    );

    mrgs_ram #(.WIDTH(DATA_W), .DEPTH(MAX_ITEMS)) u_bank1 (
        .i_clk     (i_clk),
        .i_we      (we1),
        .i_waddr   (waddr),
        .i_wdata   (wdata),
        .i_raddr_a (raddr_a),
        .i_raddr_b (raddr_b),
        .o_rdata_a (b1_rd_a),
        .o_rdata_b (b1_rd_b)
    );

    assign src_a      = r_src ? b1_rd_a : b0_rd_a;
    assign src_b      = r_src ? b1_rd_b : b0_rd_b;
    assign has_i      = (r_i < r_mid);
    assign has_j      = (r_j < r_hi);
    // left run wins on ties
    assign take_a     = has_i && (!has_j || !(src_b < src_a));
    assign merge_data = take_a ? src_a : src_b;
    assign i_nx       = r_i + t_cnt'(take_a);
    assign j_nx       = r_j + t_cnt'(!take_a);
    assign o_nx       = r_o + t_cnt'(1);
    assign pair_end   = (o_nx == r_hi);
    assign pass_end   = pair_end && (r_hi == r_count);

    assign cnt_x   = {1'b0, r_count};
    assign w2      = {r_width, 1'b0};
    assign sum_mid = {1'b0, r_hi} + {1'b0, r_width};
    assign sum_hi  = {1'b0, r_hi} + w2;
    assign nx_mid  = (sum_mid >= cnt_x) ? r_count : sum_mid[CNT_W-1:0];
    assign nx_hi   = (sum_hi >= cnt_x) ? r_count : sum_hi[CNT_W-1:0];
    assign p_mid   = (r_width >= r_count) ? r_count : r_width;
    assign p_hi    = (w2 >= cnt_x) ? r_count : w2[CNT_W-1:0];

    assign full     = (r_count == t_cnt'(MAX_ITEMS));
    assign count_nx = full ? r_count : r_count + t_cnt'(1);
    assign k_inc    = r_k + t_addr'(1);
    assign emit_end = ((t_cnt'(r_k) + t_cnt'(1)) == r_count);

    always_comb begin
        n_count   = r_count;
        n_dropped = r_dropped;
        n_src     = r_src;
        n_width   = r_width;
        n_i       = r_i;
        n_j       = r_j;
        n_mid     = r_mid;
        n_hi      = r_hi;
        n_o       = r_o;
        n_k       = r_k;
        raddr_a   = r_k;
        raddr_b   = r_k;
        waddr     = r_o[ADDR_W-1:0];
        wdata     = merge_data;
        we0       = 1'b0;
        we1       = 1'b0;
        if (i_cmd.load) begin
            if (!full) begin
                we0     = 1'b1;
                waddr   = r_count[ADDR_W-1:0];
                wdata   = i_value;
                n_count = count_nx;
            end else begin
                n_dropped = 1'b1;
            end
            if (i_cmd.start) begin
                n_width = t_cnt'(1);
                n_src   = 1'b0;
            end
        end else if (i_cmd.prime) begin
            n_i     = '0;
            n_mid   = p_mid;
            n_j     = p_mid;
            n_hi    = p_hi;
            n_o     = '0;
            raddr_a = '0;
            raddr_b = p_mid[ADDR_W-1:0];
        end else if (i_cmd.merge) begin
            we0 = r_src;
            we1 = !r_src;
            n_o = o_nx;
            if (pass_end) begin
                n_src   = !r_src;
                n_width = w2[CNT_W-1:0];
            end else if (pair_end) begin
                n_i     = r_hi;
                n_mid   = nx_mid;
                n_j     = nx_mid;
                n_hi    = nx_hi;
                raddr_a = r_hi[ADDR_W-1:0];
                raddr_b = nx_mid[ADDR_W-1:0];
            end else begin
                n_i     = i_nx;
                n_j     = j_nx;
                raddr_a = i_nx[ADDR_W-1:0];
                raddr_b = j_nx[ADDR_W-1:0];
            end
        end else if (i_cmd.emit_rd) begin
            n_k     = '0;
            raddr_a = '0;
        end else if (i_cmd.emit && i_cmd.step) begin
            if (emit_end) begin
                n_count   = '0;
                n_dropped = 1'b0;
            end else begin
                n_k     = k_inc;
                raddr_a = k_inc;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count   <= '0;
            r_dropped <= 1'b0;
        end else begin
            r_count   <= n_count;
            r_dropped <= n_dropped;
        end
    end

    always_ff @(posedge i_clk) begin
        r_src   <= n_src;
        r_width <= n_width;
        r_i     <= n_i;
        r_j     <= n_j;
        r_mid   <= n_mid;
        r_hi    <= n_hi;
        r_o     <= n_o;
        r_k     <= n_k;
    end

    assign o_stat.multi    = (count_nx >= t_cnt'(2));
    assign o_stat.pass_end = pass_end;
    assign o_stat.sort_end = pass_end && (w2 >= cnt_x);
    assign o_stat.emit_end = emit_end;

    assign o_sorted_value = src_a;
    assign o_end_of_batch = emit_end;
    assign o_overflow     = r_dropped;

endmodule

`default_nettype wire

### rtl/merge_sorter.sv
// Merge sorter top level: controller plus datapath behind valid/ready channels.
// Depends on mrgs_pkg, mrgs_if, mrgs_ctrl, mrgs_datapath.
//
// Collects a batch of signed 32-bit values, one item per cycle, until an item
// with last set; up to MAX_ITEMS (64) values are kept, later ones are dropped
// and every result of that batch then carries overflow. The batch is then
// sorted ascending with a stable bottom-up merge sort between two ping-pong
// memories that each have two read ports: each pass fetches the run heads,
// then does one merge step per entry, and there are ceil(log2 n) passes.
// Sorted values leave one per cycle while the receiver is ready, after a fetch
// of the first, with end_of_batch on the largest. No input is taken while a
// batch is sorted or emitted. No memory clearing after reset.
`default_nettype none

module merge_sorter import mrgs_pkg::*; (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    mrgs_in_if.sink    i_item,
    mrgs_out_if.source o_result
);

    t_dp_cmd  cmd;
    t_dp_stat stat;

    mrgs_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_item.valid),
        .i_in_last   (i_item.last),
        .i_out_ready (o_result.ready),
        .i_stat      (stat),
        .o_in_ready  (i_item.ready),
        .o_out_valid (o_result.valid),
        .o_cmd       (cmd)
    );

    mrgs_datapath u_datapath (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (cmd),
        .o_stat         (stat),
        .i_value        (i_item.value),
        .o_sorted_value (o_result.sorted_value),
        .o_end_of_batch (o_result.end_of_batch),
        .o_overflow     (o_result.overflow)
    );

endmodule

`default_nettype wire

### rtl/mrgs_checker.sv
// Merge sorter port checker and its bind onto merge_sorter.
// Depends on mrgs_pkg.
`default_nettype none

module mrgs_checker import mrgs_pkg::*; (
    input wire logic  i_clk,
    input wire logic  i_rst_n,
    input wire logic  i_in_ready,
    input wire logic  i_out_valid,
    input wire logic  i_out_ready,
    input wire t_data i_sorted_value,
    input wire logic  i_end_of_batch,
    input wire logic  i_overflow
);

    logic  out_fire;
    logic  r_seen;
    t_data r_prev;

    assign out_fire = i_out_valid && i_out_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seen <= 1'b0;
        end else if (out_fire) begin
            r_seen <= !i_end_of_batch;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_fire) begin
            r_prev <= i_sorted_value;
        end
    end

    a_no_overlap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_in_ready && i_out_valid))
        else $error("input taken while results pending");

    a_ascending: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_fire && r_seen |-> (i_sorted_value >= r_prev))
        else $error("results out of order");

    a_batch_close: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_fire && i_end_of_batch |=> i_in_ready && !i_out_valid)
        else $error("no return to loading after end of batch");

    a_ovf_steady: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && $past(i_out_valid) |-> $stable(i_overflow))
        else $error("overflow changed within a batch");

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_sorted_value))
        else $error("stalled item changed");

endmodule

bind merge_sorter mrgs_checker u_mrgs_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .i_in_ready     (i_item.ready),
    .i_out_valid    (o_result.valid),
    .i_out_ready    (o_result.ready),
    .i_sorted_value (o_result.sorted_value),
    .i_end_of_batch (o_result.end_of_batch),
    .i_overflow     (o_result.overflow)
);

`default_nettype wire

### bench/tb_merge_sorter.sv
// Testbench for merge_sorter: sends batches of signed values through the input channel
// and checks each sorted result against a batch predictor kept in the bench.
// Depends on mrgs_pkg, mrgs_if and merge_sorter.
`default_nettype none

module tb_merge_sorter;
    import mrgs_pkg::*;

    localparam int unsigned CYCLE_LIMIT = 200000;
    localparam int          HOLD_CYCLES = 400;

    typedef struct packed {
        t_data value;
        logic  eob;
        logic  ovf;
    } t_sorted_entry;

    logic clk = 1'b0;
    logic rst_n;

    mrgs_in_if  in_ch ();
    mrgs_out_if out_ch ();

    merge_sorter uut (
        .i_clk    (clk),
        .i_rst_n  (rst_n),
        .i_item   (in_ch.sink),
        .o_result (out_ch.source)
    );

    t_data         batch_vals[$];
    logic          batch_dropped = 1'b0;
    t_sorted_entry sorted_expect[$];

    int          errors        = 0;
    int unsigned cycle_cnt     = 0;
    int          in_idle_pct   = 0;
    int          out_stall_pct = 0;
    int          hold_req      = 0;
    int          hold_ack      = 0;
    int          hold_left     = 0;

    always #1 clk = ~clk;

    always @(posedge clk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt > CYCLE_LIMIT) begin
            $display("%0t: timeout after %0d cycles", $time, cycle_cnt);
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    // receiver: random stalls, plus a long hold-off on request
    always @(posedge clk) begin
        if (hold_ack != hold_req) begin
            hold_ack     <= hold_req;
            hold_left    <= HOLD_CYCLES;
            out_ch.ready <= 1'b0;
        end else if (hold_left != 0) begin
            hold_left    <= hold_left - 1;
            out_ch.ready <= 1'b0;
        end else begin
            out_ch.ready <= ($urandom_range(99) >= out_stall_pct);
        end
    end

    always @(posedge clk) begin : check_result
        t_sorted_entry exp_e;
        if (rst_n && out_ch.valid && out_ch.ready) begin
            if (sorted_expect.size() == 0) begin
                errors++;
                $display("%0t: unexpected result: value %0d eob %b ovf %b", $time,
                         out_ch.sorted_value, out_ch.end_of_batch, out_ch.overflow);
            end else begin
                exp_e = sorted_expect.pop_front();
                if ({exp_e.value, exp_e.eob, exp_e.ovf} !==
                    {out_ch.sorted_value, out_ch.end_of_batch, out_ch.overflow}) begin
                    errors++;
                    $display("%0t: expected value %0d eob %b ovf %b, got value %0d eob %b ovf %b",
                             $time, exp_e.value, exp_e.eob, exp_e.ovf, out_ch.sorted_value,
                             out_ch.end_of_batch, out_ch.overflow);
                end
            end
        end
    end

    // batch predictor: store or drop, then stable sort on the closing item
    task automatic sorter_accept(input t_data v, input logic l);
        t_data sorted[$];
        t_data key;
        int    j;
        if (batch_vals.size() < MAX_ITEMS)
            batch_vals.push_back(v);
        else
            batch_dropped = 1'b1;
        if (l) begin
            sorted = batch_vals;
            for (int i = 1; i < sorted.size(); i++) begin
                key = sorted[i];
                j   = i - 1;
                while (j >= 0 && sorted[j] > key) begin
                    sorted[j + 1] = sorted[j];
                    j--;
                end
                sorted[j + 1] = key;
            end
            foreach (sorted[k])
                sorted_expect.push_back('{sorted[k], k == sorted.size() - 1, batch_dropped});
            batch_vals.delete();
            batch_dropped = 1'b0;
        end
    endtask

    task automatic send_item(input t_data v, input logic l);
        while ($urandom_range(99) < in_idle_pct) begin
            in_ch.valid <= 1'b0;
            @(posedge clk);
        end
        in_ch.valid <= 1'b1;
        in_ch.value <= v;
        in_ch.last  <= l;
        @(posedge clk);
        while (!in_ch.ready) @(posedge clk);
        sorter_accept(v, l);
    endtask

    task automatic send_batch(input t_data vals[$]);
        foreach (vals[i])
            send_item(vals[i], i == vals.size() - 1);
    endtask

    function automatic t_data rand_value();
        case ($urandom_range(3))
            0: return t_data'($urandom_range(16)) - 8;
            1: case ($urandom_range(5))
                   0: return t_data'(32'h8000_0000);
                   1: return t_data'(32'h7FFF_FFFF);
                   2: return t_data'(32'h8000_0001);
                   3: return t_data'(32'h7FFF_FFFE);
                   4: return t_data'(0);
                   default: return t_data'(-1);
               endcase
            default: return t_data'($urandom);
        endcase
    endfunction

    task automatic send_random_batch(input int size);
        for (int i = 0; i < size; i++)
            send_item(rand_value(), i == size - 1);
    endtask

    task automatic wait_drained();
        in_ch.valid <= 1'b0;
        do @(posedge clk); while (sorted_expect.size() != 0);
        repeat (4) @(posedge clk);
    endtask

    task automatic run_random_batches(input int n_items);
        int sent;
        int size;
        sent = 0;
        while (sent < n_items) begin
            size = ($urandom_range(99) < 70) ? $urandom_range(1, 8) : $urandom_range(9, 24);
            if (size > n_items - sent)
                size = n_items - sent;
            send_random_batch(size);
            sent += size;
        end
        wait_drained();
    endtask

    task automatic test_directed();
        in_idle_pct   = 0;
        out_stall_pct = 0;
        send_batch('{t_data'(32'h7FFF_FFFF)});
        send_batch('{t_data'(32'h8000_0000)});
        send_batch('{t_data'(0), t_data'(-1), t_data'(1), t_data'(32'h7FFF_FFFF),
                     t_data'(32'h8000_0000), t_data'(-2), t_data'(32'h8000_0000)});
        send_batch('{t_data'(5), t_data'(5)});
        send_batch('{t_data'(3), t_data'(2), t_data'(1), t_data'(0), t_data'(-1)});
        send_batch('{t_data'(32'h5555_5555), t_data'(32'hAAAA_AAAA),
                     t_data'(32'h8000_0001), t_data'(32'h7FFF_FFFE)});
        wait_drained();
    endtask

    task automatic test_no_idle();
        in_idle_pct   = 0;
        out_stall_pct = 0;
        run_random_batches(35);
    endtask

    task automatic test_sender_idle();
        in_idle_pct   = 82;
        out_stall_pct = 0;
        run_random_batches(35);
    endtask

    task automatic test_receiver_stall();
        in_idle_pct   = 0;
        out_stall_pct = 82;
        run_random_batches(35);
    endtask

    task automatic test_both_idle();
        in_idle_pct   = 26;
        out_stall_pct = 26;
        run_random_batches(35);
    endtask

    task automatic test_full_batch();
        in_idle_pct   = 26;
        out_stall_pct = 26;
        send_random_batch(MAX_ITEMS);
        wait_drained();
    endtask

    // items past capacity are dropped, the closing one included
    task automatic test_overflow();
        in_idle_pct   = 26;
        out_stall_pct = 26;
        send_random_batch(MAX_ITEMS + 3);
        wait_drained();
    endtask

    // receiver holds off while the sender keeps offering batches
    task automatic test_backpressure();
        in_idle_pct   = 0;
        out_stall_pct = 0;
        hold_req     <= hold_req + 1;
        send_random_batch(6);
        send_random_batch(20);
        send_random_batch(5);
        wait_drained();
    endtask

    initial begin
        rst_n        = 1'b0;
        in_ch.valid  = 1'b0;
        in_ch.value  = '0;
        in_ch.last   = 1'b0;
        out_ch.ready = 1'b0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed();
        test_no_idle();
        test_sender_idle();
        test_receiver_stall();
        test_both_idle();
        test_full_batch();
        test_overflow();
        test_backpressure();

        repeat (40) @(posedge clk);
        if (errors == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule

`default_nettype wire

### filelist.f
rtl/mrgs_pkg.sv
rtl/mrgs_if.sv
rtl/mrgs_ram.sv
rtl/mrgs_ctrl.sv
rtl/mrgs_datapath.sv
rtl/merge_sorter.sv
rtl/mrgs_checker.sv
bench/tb_merge_sorter.sv
